### sv/assert_macros.svh
// assertion helpers for the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every clock edge, muted while reset is held
`define DSM_ASSERT_RST(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// property checked on every clock edge, reset included
`define DSM_ASSERT_ALWAYS(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### sv/dsm_pkg.sv
package dsm_pkg;

	// field widths
	localparam int unsigned COORD_W = 24;
	localparam int unsigned MASS_W  = 16;
	localparam int unsigned MSD_W   = 40;
	localparam int unsigned SQ_W    = 49;   // square of a 25-bit difference
	localparam int unsigned SUM3_W  = 50;   // up to three squares
	localparam int unsigned S_W     = 38;   // sum after the Q.24 -> Q.12 shift
	localparam int unsigned W_W     = 54;   // s times mass
	localparam int unsigned SSUM_W  = 64;
	localparam int unsigned MSUM_W  = 32;
	localparam int unsigned FRAC_SH = 12;

	// group limit and counter width
	localparam int unsigned MAX_ATOMS = 4096;
	localparam int unsigned COUNT_W   = $clog2(MAX_ATOMS + 1);

	// divider
	localparam int unsigned DIV_STEPS = SSUM_W;
	localparam int unsigned DCNT_W    = $clog2(DIV_STEPS + 1);

	// register indexes
	localparam int unsigned CIDX_W = 2;
	localparam int unsigned CDAT_W = 3;
	localparam logic [CIDX_W-1:0] REG_MODE = 2'd0;
	localparam logic [CIDX_W-1:0] REG_EXCL = 2'd1;
	localparam logic [CIDX_W-1:0] REG_MW   = 2'd2;

	// displacement modes
	localparam logic [2:0] MODE_ALL = 3'd0;
	localparam logic [2:0] MODE_X   = 3'd1;
	localparam logic [2:0] MODE_Y   = 3'd2;
	localparam logic [2:0] MODE_Z   = 3'd3;
	localparam logic [2:0] MODE_LAT = 3'd4;

	// axis codes
	localparam logic [1:0] AXIS_X = 2'd0;
	localparam logic [1:0] AXIS_Y = 2'd1;
	localparam logic [1:0] AXIS_Z = 2'd2;

	typedef struct packed {
		logic [2:0] mode;
		logic [1:0] excl;
		logic       mw;
	} dsm_cfg_t;

	typedef struct packed {
		logic load_in;
		logic sq_en;
		logic wt_en;
		logic acc_en;
		logic div_start;
		logic out_load;
	} dsm_cmd_t;

	typedef struct packed {
		logic last_s3;
		logic div_busy;
		logic out_free;
	} dsm_stat_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SQUARE,
		ST_WEIGHT,
		ST_ACCUM,
		ST_START,
		ST_DIVIDE,
		ST_DELIVER
	} dsm_state_t;

endpackage

### sv/dsm_div.sv
module dsm_div import dsm_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [SSUM_W-1:0] dividend,
	input  logic [MSUM_W-1:0] divisor,
	output logic              busy,
	output logic              zero,
	output logic [SSUM_W-1:0] quot
);

	logic              run_q;
	logic [DCNT_W-1:0] cnt_q;
	logic [MSUM_W-1:0] rem_q;
	logic [MSUM_W-1:0] dsr_q;
	logic [SSUM_W-1:0] quo_q;
	logic              zero_q;
	logic [MSUM_W:0]   rem_sh;
	logic [MSUM_W:0]   rem_sub;
	logic              fits;

	// one restoring step: shift in the next dividend bit, try the subtract
	always_comb begin
		rem_sh  = {rem_q, quo_q[SSUM_W-1]};
		rem_sub = rem_sh - {1'b0, dsr_q};
		fits    = (rem_sh >= {1'b0, dsr_q});
	end

	// control of the iteration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			cnt_q <= '0;
		end else if (start) begin
			run_q <= 1'b1;
			cnt_q <= DCNT_W'(DIV_STEPS);
		end else if (run_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == DCNT_W'(1)) begin
				run_q <= 1'b0;
			end
		end
	end

	// dividend shifts out at the top while quotient bits shift in below
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= '0;
			dsr_q  <= divisor;
			quo_q  <= dividend;
			zero_q <= (divisor == '0);
		end else if (run_q) begin
			if (fits) begin
				rem_q <= rem_sub[MSUM_W-1:0];
			end else begin
				rem_q <= rem_sh[MSUM_W-1:0];
			end
			quo_q <= {quo_q[SSUM_W-2:0], fits};
		end
	end

	assign busy = run_q;
	assign zero = zero_q;
	assign quot = quo_q;

endmodule

### sv/dsm_dp.sv
module dsm_dp import dsm_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  dsm_cfg_t           cfg,
	input  dsm_cmd_t           cmd,
	output dsm_stat_t          stat,
	input  logic [COORD_W-1:0] ref_x,
	input  logic [COORD_W-1:0] ref_y,
	input  logic [COORD_W-1:0] ref_z,
	input  logic [COORD_W-1:0] cur_x,
	input  logic [COORD_W-1:0] cur_y,
	input  logic [COORD_W-1:0] cur_z,
	input  logic [MASS_W-1:0]  atom_mass,
	input  logic               last_atom,
	input  logic               m_tready,
	output logic               m_tvalid,
	output logic [MSD_W-1:0]   msd_value,
	output logic               divisor_zero
);

	// input stage
	logic [COORD_W-1:0] ref_s1 [3];
	logic [COORD_W-1:0] cur_s1 [3];
	logic [MASS_W-1:0]  mass_s1;
	logic               last_s1;

	// square stage
	logic [SQ_W-1:0]    sq_s2 [3];
	logic [MASS_W-1:0]  mass_s2;
	logic               last_s2;

	// weight stage
	logic [S_W-1:0]     s_s3;
	logic [W_W-1:0]     w_s3;
	logic [MASS_W-1:0]  mass_s3;
	logic               heavy_s3;
	logic               last_s3;

	// group accumulators
	logic [SSUM_W-1:0]  ssum_q;
	logic [MSUM_W-1:0]  msum_q;
	logic [COUNT_W-1:0] count_q;

	// result register
	logic               out_valid_q;
	logic [MSD_W-1:0]   msd_q;
	logic               dz_q;

	logic [SQ_W-1:0]    sq_c [3];
	logic [2:0]         use_axis;
	logic [SUM3_W-1:0]  sum3;
	logic [S_W-1:0]     s_c;
	logic [W_W-1:0]     w_c;
	logic [SSUM_W-1:0]  addend;
	logic [SSUM_W:0]    ssum_add;
	logic [MSUM_W:0]    msum_add;
	logic               room;
	logic               div_busy;
	logic               div_zero;
	logic [SSUM_W-1:0]  div_quot;
	logic [MSUM_W-1:0]  divisor_c;

	// capture the atom
	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			ref_s1[0] <= ref_x;
			ref_s1[1] <= ref_y;
			ref_s1[2] <= ref_z;
			cur_s1[0] <= cur_x;
			cur_s1[1] <= cur_y;
			cur_s1[2] <= cur_z;
			mass_s1   <= atom_mass;
			last_s1   <= last_atom;
		end
	end

	// per-axis difference magnitude and square
	always_comb begin
		logic signed [COORD_W:0] d;
		logic [COORD_W:0]        mag;
		logic [2*COORD_W+1:0]    prod;
		for (int i = 0; i < 3; i++) begin
			d       = $signed({ref_s1[i][COORD_W-1], ref_s1[i]})
			        - $signed({cur_s1[i][COORD_W-1], cur_s1[i]});
			mag     = d[COORD_W] ? (~d + 1'b1) : d;
			prod    = (2*COORD_W+2)'(mag) * (2*COORD_W+2)'(mag);
			sq_c[i] = prod[SQ_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.sq_en) begin
			sq_s2   <= sq_c;
			mass_s2 <= mass_s1;
			last_s2 <= last_s1;
		end
	end

	// axes taken by the current mode
	always_comb begin
		case (cfg.mode)
			MODE_X:   use_axis = 3'b001;
			MODE_Y:   use_axis = 3'b010;
			MODE_Z:   use_axis = 3'b100;
			MODE_LAT: begin
				use_axis = 3'b111;
				case (cfg.excl)
					AXIS_X:  use_axis = 3'b110;
					AXIS_Y:  use_axis = 3'b101;
					AXIS_Z:  use_axis = 3'b011;
					default: use_axis = 3'b111;
				endcase
			end
			default:  use_axis = 3'b111;
		endcase
	end

	// sum, drop to Q.12, weight by mass
	always_comb begin
		sum3 = '0;
		for (int i = 0; i < 3; i++) begin
			if (use_axis[i]) begin
				sum3 = sum3 + SUM3_W'(sq_s2[i]);
			end
		end
		s_c = sum3[SUM3_W-1:FRAC_SH];
		w_c = W_W'(s_c) * W_W'(mass_s2);
	end

	always_ff @(posedge clk) begin
		if (cmd.wt_en) begin
			s_s3     <= s_c;
			w_s3     <= w_c;
			mass_s3  <= mass_s2;
			heavy_s3 <= (mass_s2[MASS_W-1:8] != '0);
			last_s3  <= last_s2;
		end
	end

	// saturating accumulation
	always_comb begin
		room     = (count_q < COUNT_W'(MAX_ATOMS));
		addend   = cfg.mw ? SSUM_W'(w_s3) : SSUM_W'(s_s3);
		ssum_add = {1'b0, ssum_q} + {1'b0, addend};
		msum_add = {1'b0, msum_q} + (MSUM_W+1)'(mass_s3);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ssum_q  <= '0;
			msum_q  <= '0;
			count_q <= '0;
		end else if (cmd.div_start) begin
			ssum_q  <= '0;
			msum_q  <= '0;
			count_q <= '0;
		end else if (cmd.acc_en && room) begin
			count_q <= count_q + 1'b1;
			if (!cfg.mw || heavy_s3) begin
				ssum_q <= ssum_add[SSUM_W] ? '1 : ssum_add[SSUM_W-1:0];
			end
			if (cfg.mw && heavy_s3) begin
				msum_q <= msum_add[MSUM_W] ? '1 : msum_add[MSUM_W-1:0];
			end
		end
	end

	// divide the group sum by total mass or atom count
	assign divisor_c = cfg.mw ? msum_q : MSUM_W'(count_q);

	dsm_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (ssum_q),
		.divisor  (divisor_c),
		.busy     (div_busy),
		.zero     (div_zero),
		.quot     (div_quot)
	);

	// result register, parts the divider from the output handshake
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			dz_q <= div_zero;
			if (div_zero) begin
				msd_q <= '0;
			end else if (div_quot[SSUM_W-1:MSD_W] != '0) begin
				msd_q <= '1;
			end else begin
				msd_q <= div_quot[MSD_W-1:0];
			end
		end
	end

	assign stat.last_s3  = last_s3;
	assign stat.div_busy = div_busy;
	assign stat.out_free = !out_valid_q || m_tready;

	assign m_tvalid     = out_valid_q;
	assign msd_value    = msd_q;
	assign divisor_zero = dz_q;

endmodule

### sv/dsm_ctrl.sv
module dsm_ctrl import dsm_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      s_tvalid,
	output logic      s_tready,
	input  dsm_stat_t stat,
	output dsm_cmd_t  cmd
);

	dsm_state_t state_q;
	dsm_state_t state_nx;
	logic       accept;

	// an item may enter while the previous one accumulates, unless that one ends the group
	assign s_tready = (state_q == ST_IDLE) || (state_q == ST_ACCUM && !stat.last_s3);
	assign accept   = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	// next state
	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) state_nx = ST_SQUARE;
			end
			ST_SQUARE: state_nx = ST_WEIGHT;
			ST_WEIGHT: state_nx = ST_ACCUM;
			ST_ACCUM: begin
				if (stat.last_s3) begin
					state_nx = ST_START;
				end else if (accept) begin
					state_nx = ST_SQUARE;
				end else begin
					state_nx = ST_IDLE;
				end
			end
			ST_START: state_nx = ST_DIVIDE;
			ST_DIVIDE: begin
				if (!stat.div_busy) state_nx = ST_DELIVER;
			end
			ST_DELIVER: begin
				if (stat.out_free) state_nx = ST_IDLE;
			end
			default: state_nx = ST_IDLE;
		endcase
	end

	// datapath commands
	always_comb begin
		cmd = '0;
		cmd.load_in = accept;
		unique case (state_q)
			ST_SQUARE:  cmd.sq_en     = 1'b1;
			ST_WEIGHT:  cmd.wt_en     = 1'b1;
			ST_ACCUM:   cmd.acc_en    = 1'b1;
			ST_START:   cmd.div_start = 1'b1;
			ST_DELIVER: cmd.out_load  = stat.out_free;
			default: ;
		endcase
	end

endmodule

### sv/displacement_square_mean.sv
// channel   dir  handshake                  payload
// s_*       in   s_tvalid / s_tready        s_tdata: atom positions and mass, s_tlast: last atom
// m_*       out  m_tvalid / m_tready        m_tdata: msd_value, m_tuser: divisor_zero
// cfg_*     in   cfg_valid / cfg_ready      cfg_index, cfg_data
//
// an atom passes three steps (square, weight, accumulate); the next atom may enter during
// the accumulate step unless the atom there ends the group, so atoms of a group overlap.
// the last atom then adds a start step, 64 divider steps, a step to see the divider done
// and one to load the result register, after which m_tvalid rises.
// arst_n clears the state machine, the accumulators, the result flag and the registers
// (mode 0, excluded axis 0, mass weighting on); a held result stalls only the next group end.
module displacement_square_mean import dsm_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	// ref_x, ref_y, ref_z, cur_x, cur_y, cur_z, atom_mass
	input  logic [159:0]        s_tdata,
	input  logic                s_tlast,
	output logic                m_tvalid,
	input  logic                m_tready,
	// msd_value
	output logic [MSD_W-1:0]    m_tdata,
	// divisor_zero
	output logic                m_tuser,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [CIDX_W-1:0]   cfg_index,
	input  logic [CDAT_W-1:0]   cfg_data
);

	dsm_cfg_t  cfg_q;
	dsm_cmd_t  cmd;
	dsm_stat_t stat;

	// configuration registers
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.mode <= MODE_ALL;
			cfg_q.excl <= AXIS_X;
			cfg_q.mw   <= 1'b1;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_MODE: cfg_q.mode <= cfg_data;
				REG_EXCL: cfg_q.excl <= cfg_data[1:0];
				REG_MW:   cfg_q.mw   <= cfg_data[0];
				default: ;
			endcase
		end
	end

	dsm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	dsm_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.cmd          (cmd),
		.stat         (stat),
		.ref_x        (s_tdata[23:0]),
		.ref_y        (s_tdata[47:24]),
		.ref_z        (s_tdata[71:48]),
		.cur_x        (s_tdata[95:72]),
		.cur_y        (s_tdata[119:96]),
		.cur_z        (s_tdata[143:120]),
		.atom_mass    (s_tdata[159:144]),
		.last_atom    (s_tlast),
		.m_tready     (m_tready),
		.m_tvalid     (m_tvalid),
		.msd_value    (m_tdata),
		.divisor_zero (m_tuser)
	);

endmodule

### sv/dsm_checker.sv
`include "assert_macros.svh"

module dsm_checker import dsm_pkg::*; (
	input logic             clk,
	input logic             arst_n,
	input logic             s_tvalid,
	input logic             s_tready,
	input logic             m_tvalid,
	input logic             m_tready,
	input logic [MSD_W-1:0] m_tdata,
	input logic             m_tuser
);

	// no result shows while reset is held
	`DSM_ASSERT_ALWAYS(a_no_result_in_reset, clk, !arst_n |-> !m_tvalid, "valid in reset")

	// a zero divisor always comes with a zero value
	`DSM_ASSERT_RST(a_zero_div, clk, arst_n, m_tvalid && m_tuser |-> m_tdata == '0, "nonzero value")

	// an accepted item occupies the square stage next cycle
	`DSM_ASSERT_RST(a_busy_after, clk, arst_n, s_tvalid && s_tready |=> !s_tready, "ready after item")

	// a pending result is held until taken
	`DSM_ASSERT_RST(a_result_holds, clk, arst_n, m_tvalid && !m_tready |=> m_tvalid, "result dropped")

endmodule

bind displacement_square_mean dsm_checker u_dsm_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);

### bench/testbench.sv
`timescale 1ns / 1ps

module testbench;
	import dsm_pkg::*;

	localparam int STALL_LIMIT = 2000;
	localparam int SINK_HOLD   = 400;
	localparam int SETTLE_WAIT = 8;
	localparam int DRAIN_WAIT  = 100;
	localparam int PHASES      = 10;
	localparam int PHASE_ATOMS = 80;
	localparam int COORD_MAX   = 8388607;
	localparam int COORD_MIN   = -8388608;
	localparam logic [MASS_W-1:0] LIGHT_MASS = 16'd256;
	localparam logic [MSD_W-1:0]  MSD_MAX    = '1;

	// register values beyond the package codes
	localparam logic [CDAT_W-1:0] MODE_UNDEF_LO = 3'd5;
	localparam logic [CDAT_W-1:0] MODE_UNDEF_HI = 3'd7;
	localparam logic [CDAT_W-1:0] EXCL_NONE     = 3'd3;
	localparam logic [CDAT_W-1:0] MW_OFF        = 3'd0;
	localparam logic [CDAT_W-1:0] MW_ON         = 3'd1;

	// one atom, laid out exactly as s_tdata
	typedef struct packed {
		logic [MASS_W-1:0]         mass;
		logic signed [COORD_W-1:0] cur_z;
		logic signed [COORD_W-1:0] cur_y;
		logic signed [COORD_W-1:0] cur_x;
		logic signed [COORD_W-1:0] ref_z;
		logic signed [COORD_W-1:0] ref_y;
		logic signed [COORD_W-1:0] ref_x;
	} atom_t;

	typedef struct packed {
		logic [MSD_W-1:0] value;
		logic             zero;
	} msd_t;

	typedef struct {
		logic              wr;
		logic [CIDX_W-1:0] idx;
		logic [CDAT_W-1:0] val;
		atom_t             atom;
		logic              last;
		logic              typed;
		msd_t              res;
	} plan_row_t;

	logic               clk       = 1'b0;
	logic               arst_n    = 1'b1;
	logic               s_tvalid  = 1'b0;
	logic               s_tready;
	logic [159:0]       s_tdata   = '0;
	logic               s_tlast   = 1'b0;
	logic               m_tvalid;
	logic               m_tready  = 1'b0;
	logic [MSD_W-1:0]   m_tdata;
	logic               m_tuser;
	logic               cfg_valid = 1'b0;
	logic               cfg_ready;
	logic [CIDX_W-1:0]  cfg_index = '0;
	logic [CDAT_W-1:0]  cfg_data  = '0;

	// register copies and group accumulators of the predictor
	logic [2:0]         mode_reg;
	logic [1:0]         excl_reg;
	logic               mw_reg;
	logic [SSUM_W-1:0]  sq_total;
	logic [MSUM_W-1:0]  mass_total;
	int unsigned        atom_total;

	msd_t               expected_msd[$];
	plan_row_t          plan[$];
	int                 fail_count   = 0;
	int                 quiet_cycles = 0;
	int                 send_gap_pct = 0;
	int                 sink_gap_pct = 0;
	logic               hold_sink    = 1'b0;

	displacement_square_mean u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tlast   (s_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// 50 MHz clock
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// squared distance along one axis, Q.24
	function automatic logic [SUM3_W-1:0] axis_square(logic signed [COORD_W-1:0] r,
			logic signed [COORD_W-1:0] c);
		logic signed [COORD_W:0] d;
		logic [COORD_W:0]        mag;
		logic [SUM3_W-1:0]       m;
		d   = r - c;
		mag = d[COORD_W] ? -d : d;
		m   = SUM3_W'(mag);
		return m * m;
	endfunction

	// fold one atom into the group, give the mean on the last atom
	function automatic logic predict_msd(input atom_t a, input logic last, output msd_t res);
		logic [SUM3_W-1:0] q24;
		logic [S_W-1:0]    s;
		logic [W_W-1:0]    w;
		logic [SSUM_W:0]   t;
		logic [MSUM_W:0]   ms;
		logic [SSUM_W-1:0] dv;
		logic [SSUM_W-1:0] q;
		res = '0;
		q24 = '0;
		if (atom_total < MAX_ATOMS) begin
			case (mode_reg)
				MODE_X: q24 = axis_square(a.ref_x, a.cur_x);
				MODE_Y: q24 = axis_square(a.ref_y, a.cur_y);
				MODE_Z: q24 = axis_square(a.ref_z, a.cur_z);
				MODE_LAT: begin
					if (excl_reg != AXIS_X) q24 = q24 + axis_square(a.ref_x, a.cur_x);
					if (excl_reg != AXIS_Y) q24 = q24 + axis_square(a.ref_y, a.cur_y);
					if (excl_reg != AXIS_Z) q24 = q24 + axis_square(a.ref_z, a.cur_z);
				end
				default: begin
					q24 = axis_square(a.ref_x, a.cur_x) + axis_square(a.ref_y, a.cur_y)
						+ axis_square(a.ref_z, a.cur_z);
				end
			endcase
			s = q24[SUM3_W-1:FRAC_SH];
			if (mw_reg) begin
				// light atoms only count toward the group length
				if (a.mass >= LIGHT_MASS) begin
					w          = W_W'(s) * W_W'(a.mass);
					t          = {1'b0, sq_total} + (SSUM_W+1)'(w);
					sq_total   = t[SSUM_W] ? '1 : t[SSUM_W-1:0];
					ms         = {1'b0, mass_total} + (MSUM_W+1)'(a.mass);
					mass_total = ms[MSUM_W] ? '1 : ms[MSUM_W-1:0];
				end
			end else begin
				t        = {1'b0, sq_total} + (SSUM_W+1)'(s);
				sq_total = t[SSUM_W] ? '1 : t[SSUM_W-1:0];
			end
			atom_total++;
		end
		if (!last)
			return 1'b0;
		dv = mw_reg ? SSUM_W'(mass_total) : SSUM_W'(atom_total);
		if (dv == '0) begin
			res.zero = 1'b1;
		end else begin
			q         = sq_total / dv;
			res.value = (q > SSUM_W'(MSD_MAX)) ? MSD_MAX : q[MSD_W-1:0];
		end
		sq_total   = '0;
		mass_total = '0;
		atom_total = 0;
		return 1'b1;
	endfunction

	function automatic atom_t mk_atom(int rx, int ry, int rz, int cx, int cy, int cz, int m);
		atom_t a;
		a.ref_x = rx[COORD_W-1:0];
		a.ref_y = ry[COORD_W-1:0];
		a.ref_z = rz[COORD_W-1:0];
		a.cur_x = cx[COORD_W-1:0];
		a.cur_y = cy[COORD_W-1:0];
		a.cur_z = cz[COORD_W-1:0];
		a.mass  = m[MASS_W-1:0];
		return a;
	endfunction

	function automatic plan_row_t atom_row(atom_t a, logic last, logic typed, msd_t res);
		plan_row_t r;
		r       = '{default: '0};
		r.atom  = a;
		r.last  = last;
		r.typed = typed;
		r.res   = res;
		return r;
	endfunction

	function automatic plan_row_t reg_row(logic [CIDX_W-1:0] idx, logic [CDAT_W-1:0] val);
		plan_row_t r;
		r     = '{default: '0};
		r.wr  = 1'b1;
		r.idx = idx;
		r.val = val;
		return r;
	endfunction

	function automatic logic [COORD_W-1:0] extreme_coord();
		case ($urandom_range(0, 3))
			0: return 24'h7FFFFF;
			1: return 24'h800000;
			2: return 24'h000000;
			default: return 24'hFFFFFF;
		endcase
	endfunction

	function automatic logic [COORD_W-1:0] small_step();
		int v;
		v = $urandom_range(0, 8191) - 4096;
		return v[COORD_W-1:0];
	endfunction

	function automatic atom_t random_atom();
		atom_t a;
		a = {$urandom, $urandom, $urandom, $urandom, $urandom};
		case ($urandom_range(0, 3))
			0: begin
				// short hop from the reference position
				a.cur_x = a.ref_x + small_step();
				a.cur_y = a.ref_y + small_step();
				a.cur_z = a.ref_z + small_step();
			end
			1: begin
				a.ref_x = extreme_coord();
				a.ref_y = extreme_coord();
				a.ref_z = extreme_coord();
				a.cur_x = extreme_coord();
				a.cur_y = extreme_coord();
				a.cur_z = extreme_coord();
			end
			default: ;
		endcase
		case ($urandom_range(0, 7))
			0: a.mass = '0;
			1: a.mass = MASS_W'($urandom_range(1, 255));
			2: a.mass = '1;
			3: a.mass = LIGHT_MASS;
			default: ;
		endcase
		return a;
	endfunction

	// offer one atom until taken, then maybe idle a few cycles
	task automatic push_atom(input atom_t a, input logic last, input logic typed,
			input msd_t typed_res);
		msd_t got;
		s_tvalid <= 1'b1;
		s_tdata  <= a;
		s_tlast  <= last;
		do @(posedge clk); while (!s_tready);
		if (predict_msd(a, last, got))
			expected_msd.push_back(typed ? typed_res : got);
		if ($urandom_range(0, 99) < send_gap_pct) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
	endtask

	task automatic write_reg(input logic [CIDX_W-1:0] idx, input logic [CDAT_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			REG_MODE: mode_reg = val;
			REG_EXCL: excl_reg = val[1:0];
			REG_MW:   mw_reg   = val[0];
			default: ;
		endcase
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic shuffle_reg(input logic [CIDX_W-1:0] idx);
		case (idx)
			REG_MODE: write_reg(idx, CDAT_W'($urandom_range(0, 7)));
			REG_EXCL: write_reg(idx, CDAT_W'($urandom_range(0, 3)));
			default:  write_reg(idx, CDAT_W'($urandom_range(0, 1)));
		endcase
	endtask

	// stop sending, wait for all results and for the pipeline to empty
	task automatic settle();
		s_tvalid <= 1'b0;
		while (expected_msd.size() != 0) @(posedge clk);
		repeat (SETTLE_WAIT) @(posedge clk);
	endtask

	task automatic check_result();
		msd_t want;
		if (expected_msd.size() == 0) begin
			$display("%0t: result with none expected, msd_value %0d divisor_zero %0b",
				$time, m_tdata, m_tuser);
			fail_count++;
		end else begin
			want = expected_msd.pop_front();
			if (m_tdata !== want.value) begin
				$display("%0t: msd_value expected %0d actual %0d", $time, want.value, m_tdata);
				fail_count++;
			end
			if (m_tuser !== want.zero) begin
				$display("%0t: divisor_zero expected %0b actual %0b", $time, want.zero, m_tuser);
				fail_count++;
			end
		end
	endtask

	// result side: check each item, stall in bursts or on request
	initial begin : result_sink
		wait (arst_n);
		forever begin
			@(posedge clk);
			if (m_tvalid && m_tready)
				check_result();
			if (hold_sink) begin
				hold_sink = 1'b0;
				m_tready <= 1'b0;
				repeat (SINK_HOLD) @(posedge clk);
			end else if ($urandom_range(0, 99) < sink_gap_pct) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 5)) @(posedge clk);
			end
			m_tready <= 1'b1;
		end
	end

	// watchdog on cycles without any handshake on the atom, result or register channel
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= STALL_LIMIT) begin
			$display("testbench failed");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin : stimulus
		atom_t probe;
		atom_t far_out;
		atom_t far_back;
		int    phase;
		int    sent;
		int    glen;
		int    k;
		arst_n     <= 1'b0;
		mode_reg   = MODE_ALL;
		excl_reg   = AXIS_X;
		mw_reg     = 1'b1;
		sq_total   = '0;
		mass_total = '0;
		atom_total = 0;

		probe    = mk_atom(4096, -8192, 12288, -4096, 20000, -123456, 512);
		far_out  = mk_atom(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MIN, COORD_MIN, COORD_MIN,
			65535);
		far_back = mk_atom(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, COORD_MAX,
			255);

		// massless atom alone: nothing to divide by
		plan.push_back(atom_row(mk_atom(0, 0, 0, 0, 0, 0, 0), 1'b1, 1'b1, {40'd0, 1'b1}));
		// widest displacement on all axes, heaviest atom
		plan.push_back(atom_row(far_out, 1'b1, 1'b1, {40'd206158405632, 1'b0}));
		// same distance reversed, a light atom skipped before it
		plan.push_back(atom_row(far_back, 1'b0, 1'b0, '0));
		far_back.mass = LIGHT_MASS;
		plan.push_back(atom_row(far_back, 1'b1, 1'b0, '0));
		// single axes
		plan.push_back(reg_row(REG_MODE, MODE_X));
		plan.push_back(atom_row(probe, 1'b1, 1'b0, '0));
		plan.push_back(reg_row(REG_MODE, MODE_Y));
		plan.push_back(atom_row(probe, 1'b1, 1'b0, '0));
		plan.push_back(reg_row(REG_MODE, MODE_Z));
		plan.push_back(atom_row(probe, 1'b1, 1'b0, '0));
		// lateral with each axis left out, then with none left out
		plan.push_back(reg_row(REG_MODE, MODE_LAT));
		plan.push_back(reg_row(REG_EXCL, {1'b0, AXIS_X}));
		plan.push_back(atom_row(probe, 1'b1, 1'b0, '0));
		plan.push_back(reg_row(REG_EXCL, {1'b0, AXIS_Y}));
		plan.push_back(atom_row(probe, 1'b1, 1'b0, '0));
		plan.push_back(reg_row(REG_EXCL, {1'b0, AXIS_Z}));
		plan.push_back(atom_row(probe, 1'b1, 1'b0, '0));
		plan.push_back(reg_row(REG_EXCL, EXCL_NONE));
		plan.push_back(atom_row(probe, 1'b1, 1'b0, '0));
		// undefined modes fall back to all axes
		plan.push_back(reg_row(REG_MODE, MODE_UNDEF_LO));
		plan.push_back(atom_row(probe, 1'b1, 1'b0, '0));
		plan.push_back(reg_row(REG_MODE, MODE_UNDEF_HI));
		plan.push_back(atom_row(probe, 1'b1, 1'b0, '0));
		// plain mean, massless atoms still counted
		plan.push_back(reg_row(REG_MODE, MODE_ALL));
		plan.push_back(reg_row(REG_MW, MW_OFF));
		plan.push_back(atom_row(mk_atom(-1, 0, 1, 1, 0, -1, 0), 1'b0, 1'b0, '0));
		plan.push_back(atom_row(probe, 1'b1, 1'b0, '0));
		// weighting dropped mid group: weighted sum over the count saturates
		plan.push_back(reg_row(REG_MW, MW_ON));
		plan.push_back(atom_row(far_out, 1'b0, 1'b0, '0));
		plan.push_back(reg_row(REG_MW, MW_OFF));
		plan.push_back(atom_row(mk_atom(0, 0, 0, 0, 0, 0, 0), 1'b1, 1'b1, {MSD_MAX, 1'b0}));
		// weighted group of light atoms only
		plan.push_back(reg_row(REG_MW, MW_ON));
		plan.push_back(atom_row(mk_atom(9, 9, 9, 0, 0, 0, 1), 1'b0, 1'b0, '0));
		plan.push_back(atom_row(mk_atom(0, 0, 0, 9, 9, 9, 255), 1'b1, 1'b1, {40'd0, 1'b1}));
		// axis mode switched mid group
		plan.push_back(reg_row(REG_MODE, MODE_X));
		plan.push_back(atom_row(probe, 1'b0, 1'b0, '0));
		plan.push_back(reg_row(REG_MODE, MODE_ALL));
		plan.push_back(atom_row(probe, 1'b1, 1'b0, '0));

		// reset
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed rows
		send_gap_pct = 20;
		sink_gap_pct = 20;
		foreach (plan[i]) begin
			if (plan[i].wr) begin
				settle();
				write_reg(plan[i].idx, plan[i].val);
			end else begin
				push_atom(plan[i].atom, plan[i].last, plan[i].typed, plan[i].res);
			end
		end

		// random groups under changing settings
		for (phase = 0; phase < PHASES; phase++) begin
			settle();
			if (phase >= PHASES - 2) begin
				send_gap_pct = 0;
				sink_gap_pct = 0;
			end else begin
				send_gap_pct = (phase % 3 == 1) ? 0 : 25;
				sink_gap_pct = (phase % 3 == 2) ? 0 : 25;
			end
			case (phase)
				0: begin
					write_reg(REG_MODE, MODE_UNDEF_HI);
					write_reg(REG_EXCL, EXCL_NONE);
					write_reg(REG_MW, MW_OFF);
				end
				1: begin
					write_reg(REG_MODE, MODE_ALL);
					write_reg(REG_EXCL, {1'b0, AXIS_X});
					write_reg(REG_MW, MW_ON);
				end
				default: begin
					shuffle_reg(REG_MODE);
					shuffle_reg(REG_EXCL);
					shuffle_reg(REG_MW);
				end
			endcase
			// long result back-pressure while atoms keep coming
			if (phase == 2)
				hold_sink = 1'b1;
			sent = 0;
			while (sent < PHASE_ATOMS) begin
				glen = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
				for (k = 0; k < glen; k++) begin
					if (k > 0 && $urandom_range(0, 39) == 0) begin
						settle();
						shuffle_reg(CIDX_W'($urandom_range(0, 2)));
					end
					push_atom(random_atom(), k == glen - 1, 1'b0, '0);
					sent++;
				end
			end
		end

		// drain
		settle();
		repeat (DRAIN_WAIT) @(posedge clk);
		if (fail_count == 0)
			$display("testbench passed");
		else
			$display("testbench failed");
		$finish;
	end

endmodule
